// ===== src/led_calibration_interp_table_macros.svh =====
// assertion macros for the led calibration interpolation table
// used by led_calibration_interp_table.sv, no other dependencies
`ifndef LED_CALIBRATION_INTERP_TABLE_MACROS_SVH
`define LED_CALIBRATION_INTERP_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LCIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcit assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LCIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcit assertion failed");

`endif

// ===== src/lcit_pkg.sv =====
// shared types, codes and the reset curve for the led calibration table
// no dependencies
package lcit_pkg;

    // opcodes of a request
    localparam logic [1:0] OP_CALIBRATE = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    // points per channel curve
    localparam logic [6:0] NUM_POINTS = 7'd65;

    // width used for address arithmetic before trimming to the memory size
    localparam int CALC_W = 13;

    // captured request that travels to the interpolation stage
    typedef struct packed {
        logic [1:0] op;
        logic [4:0] channel;
        logic [1:0] frac;
        logic       ch_bad;
        logic       idx_bad;
    } req_t;

    // reset curve point: 4000 * pt / 64, rounded down
    function automatic logic [11:0] ramp_point(input logic [6:0] pt);
        logic [18:0] prod;
        begin
            prod = 19'(pt) * 19'd4000;
            ramp_point = prod[17:6];
        end
    endfunction

endpackage

// ===== src/lcit_interp.sv =====
// result stage: interpolation between two curve points and status selection
// depends on lcit_pkg
module lcit_interp
(
    input  lcit_pkg::req_t req,
    input  logic [11:0]    lo_point,
    input  logic [11:0]    hi_point,
    output logic [11:0]    result_value,
    output logic           status
);

    logic [2:0]  w_lo;
    logic [13:0] mix;

    // weighted sum of the two neighboring points
    always_comb
    begin
        w_lo = 3'd4 - {1'b0, req.frac};
        mix  = 14'(lo_point) * 14'(w_lo) + 14'(hi_point) * 14'({1'b0, req.frac});
    end

    // select result and status by opcode
    always_comb
    begin
        result_value = 12'd0;
        status       = 1'b0;
        if (req.ch_bad)
        begin
            status = 1'b1;
        end
        else
        begin
            case (req.op)
                lcit_pkg::OP_CALIBRATE:
                begin
                    result_value = mix[13:2];
                end
                lcit_pkg::OP_WRITE:
                begin
                    status = req.idx_bad;
                end
                lcit_pkg::OP_READ:
                begin
                    status       = req.idx_bad;
                    result_value = req.idx_bad ? 12'd0 : lo_point;
                end
                default:
                begin
                    result_value = 12'd0;
                end
            endcase
        end
    end

endmodule

// ===== src/led_calibration_interp_table.sv =====
// top level of the led calibration interpolation table: curve memory, init sweep, control
// depends on lcit_pkg, lcit_interp and led_calibration_interp_table_macros.svh
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+--------------------------
//  request   | opcode channel level entry_index entry_value   | start high while busy low
//  result    | channel_out result_value status                | done high for one cycle
//
// a transaction first reads both points into the memory read registers, then forms the
// result and registers it; done rises with the result registers, busy is low then and the
// next start is taken at the edge that ends the cycle in which done is high.
// after reset the init sweep writes the ramp into every point, one entry a cycle,
// so busy stays high until the sweep has written the last point, before the first transaction.
// writes land at the accepting edge, so a following read sees the new point.
// the receiver cannot stall; every transaction gives exactly one result.
`include "led_calibration_interp_table_macros.svh"

module led_calibration_interp_table
#(
    parameter int NUM_CHANNELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [4:0]  channel,
    input  logic [7:0]  level,
    input  logic [6:0]  entry_index,
    input  logic [11:0] entry_value,
    output logic        done,
    output logic [4:0]  channel_out,
    output logic [11:0] result_value,
    output logic        status
);

    localparam int DEPTH  = NUM_CHANNELS * int'(lcit_pkg::NUM_POINTS);
    localparam int AW     = $clog2(DEPTH);
    localparam int WIDE_W = (AW > lcit_pkg::CALC_W) ? AW : lcit_pkg::CALC_W;
    localparam logic [8:0]    CH_LIMIT  = 9'(NUM_CHANNELS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_WORK = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] init_addr_reg, init_addr_next;
    logic [6:0]    init_pt_reg, init_pt_next;

    logic [11:0] curve_mem [DEPTH];
    logic [11:0] rd0_reg, rd1_reg;

    lcit_pkg::req_t req_reg, req_next;
    logic           done_reg;
    logic [4:0]     channel_out_reg;
    logic [11:0]    result_value_reg;
    logic           status_reg;

    logic              accept;
    logic              ch_bad, idx_bad;
    logic [WIDE_W-1:0] base_wide, addr0_wide;
    logic [6:0]        offset;
    logic [AW-1:0]     rd_addr0, rd_addr1;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [11:0]       wr_data;
    logic [11:0]       calc_value;
    logic              calc_status;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // request decode and range checks
    always_comb
    begin
        ch_bad     = ({4'b0, channel} >= CH_LIMIT);
        idx_bad    = (entry_index >= lcit_pkg::NUM_POINTS);
        offset     = (opcode == lcit_pkg::OP_CALIBRATE) ? {1'b0, level[7:2]} : entry_index;
        base_wide  = WIDE_W'(channel) * WIDE_W'(lcit_pkg::NUM_POINTS);
        addr0_wide = base_wide + WIDE_W'(offset);
        rd_addr0   = addr0_wide[AW-1:0];
        rd_addr1   = rd_addr0 + AW'(1);
        req_next.op      = opcode;
        req_next.channel = channel;
        req_next.frac    = level[1:0];
        req_next.ch_bad  = ch_bad;
        req_next.idx_bad = idx_bad;
    end

    // write port: init sweep or a point write transaction
    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            wr_en   = 1'b1;
            wr_addr = init_addr_reg;
            wr_data = lcit_pkg::ramp_point(init_pt_reg);
        end
        else
        begin
            wr_en   = accept && (opcode == lcit_pkg::OP_WRITE) && !ch_bad && !idx_bad;
            wr_addr = rd_addr0;
            wr_data = entry_value;
        end
    end

    // curve memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= curve_mem[rd_addr0];
        rd1_reg <= curve_mem[rd_addr1];
    end

    // control state machine and init counters
    always_comb
    begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        init_pt_next   = init_pt_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                init_addr_next = init_addr_reg + AW'(1);
                init_pt_next   = (init_pt_reg == lcit_pkg::NUM_POINTS - 7'd1) ?
                                 7'd0 : init_pt_reg + 7'd1;
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            init_pt_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            init_pt_reg   <= init_pt_next;
            done_reg      <= (state_reg == ST_WORK);
        end
    end

    // capture the request at acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    // result stage
    lcit_interp u_interp
    (
        .req          (req_reg),
        .lo_point     (rd0_reg),
        .hi_point     (rd1_reg),
        .result_value (calc_value),
        .status       (calc_status)
    );

    // result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WORK)
        begin
            channel_out_reg  <= req_reg.channel;
            result_value_reg <= calc_value;
            status_reg       <= calc_status;
        end
    end

    assign done         = done_reg;
    assign channel_out  = channel_out_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

    // checks
    `LCIT_ASSERT_NEXT(a_work_gives_done, clk, rst_n, state_reg == ST_WORK, done)
    `LCIT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `LCIT_ASSERT_NOW(a_done_after_work, clk, rst_n, done, $past(state_reg) == ST_WORK)
    `LCIT_ASSERT_NOW(a_init_busy, clk, rst_n, state_reg == ST_INIT, busy && !done)

endmodule
